// ----- hw/rtl/i2cms_pkg.sv -----
package i2cms_pkg;

	// Bits per data byte on the bus
	localparam int BYTE_BITS = 8;
	localparam logic [2:0] LAST_BIT = 3'(BYTE_BITS - 1);

	// Bus command codes
	localparam logic [2:0] CMD_START = 3'd0;
	localparam logic [2:0] CMD_STOP  = 3'd1;
	localparam logic [2:0] CMD_SEND  = 3'd2;
	localparam logic [2:0] CMD_RECV  = 3'd3;
	localparam logic [2:0] CMD_SACK  = 3'd4;
	localparam logic [2:0] CMD_RACK  = 3'd5;

	// Phase within one bit slot (start uses all four)
	localparam logic [1:0] PH_DATA = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;
	localparam logic [1:0] PH_END  = 2'd3;

	typedef struct packed {
		logic [2:0]           command;
		logic [BYTE_BITS-1:0] tx_byte;
		logic                 ack_out;
		logic [BYTE_BITS-1:0] line_bits;
		logic                 ack_line;
	} i2cms_in_t;

	typedef struct packed {
		logic                 scl_level;
		logic                 sda_level;
		logic [BYTE_BITS-1:0] rx_byte;
		logic                 ack_in;
		logic                 last;
	} i2cms_out_t;

	// Controller -> datapath
	typedef struct packed {
		logic load;
		logic step;
	} i2cms_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic cmd_ok;
		logic step_last;
	} i2cms_sts_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} i2cms_state_t;

endpackage

// ----- hw/rtl/i2cms_ctrl.sv -----
module i2cms_ctrl
	import i2cms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output i2cms_cmd_t cmd,
	input  i2cms_sts_t sts
);

	i2cms_state_t state_q, state_nxt;
	logic         out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (cmd.step && sts.step_last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid && sts.cmd_ok;
			end
			ST_RUN: begin
				cmd.step = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

	a_step_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> state_q == ST_RUN)
		else $error("step outside run");

	a_load_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == ST_IDLE)
		else $error("load outside idle");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && sts.step_last |=> state_q == ST_IDLE && out_valid_q)
		else $error("final write did not end command");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !cmd.step)
		else $error("held result overwritten");

endmodule

// ----- hw/rtl/i2cms_dp.sv -----
module i2cms_dp
	import i2cms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  i2cms_in_t  in_data,
	output i2cms_out_t out_data,
	input  i2cms_cmd_t cmd,
	output i2cms_sts_t sts
);

	logic [2:0]           cmd_q;
	logic [BYTE_BITS-1:0] sh_q;
	logic                 ack_out_q;
	logic [BYTE_BITS-1:0] line_q;
	logic                 ack_line_q;
	logic [1:0]           ph_q;
	logic [2:0]           bit_q;
	logic                 scl_q, sda_q;
	i2cms_out_t           out_q;

	logic       scl_nxt, sda_nxt, last_nxt, ack_nxt, shift_nxt;
	logic [1:0] ph_nxt;
	logic [BYTE_BITS-1:0] rx_nxt;

	// line write for the current step
	always_comb begin
		scl_nxt   = scl_q;
		sda_nxt   = sda_q;
		last_nxt  = 1'b0;
		ack_nxt   = 1'b0;
		rx_nxt    = '0;
		shift_nxt = 1'b0;
		ph_nxt    = ph_q + 2'd1;
		case (cmd_q)
			CMD_START: begin
				case (ph_q)
					PH_DATA: sda_nxt = 1'b1;
					PH_HIGH: scl_nxt = 1'b1;
					PH_LOW:  sda_nxt = 1'b0;
					default: begin
						scl_nxt  = 1'b0;
						last_nxt = 1'b1;
					end
				endcase
			end
			CMD_STOP: begin
				case (ph_q)
					PH_DATA: sda_nxt = 1'b0;
					PH_HIGH: scl_nxt = 1'b1;
					default: begin
						sda_nxt  = 1'b1;
						last_nxt = 1'b1;
					end
				endcase
			end
			CMD_SEND, CMD_RECV, CMD_SACK, CMD_RACK: begin
				case (ph_q)
					PH_DATA: begin
						case (cmd_q)
							CMD_SEND: sda_nxt = sh_q[BYTE_BITS-1];
							CMD_SACK: sda_nxt = ack_out_q;
							default:  sda_nxt = 1'b1;
						endcase
					end
					PH_HIGH: scl_nxt = 1'b1;
					default: begin
						scl_nxt = 1'b0;
						// receive skips the SDA release after its first bit
						ph_nxt    = (cmd_q == CMD_RECV) ? PH_HIGH : PH_DATA;
						shift_nxt = 1'b1;
						if (cmd_q == CMD_SEND || cmd_q == CMD_RECV) begin
							last_nxt = (bit_q == LAST_BIT);
						end else begin
							last_nxt = 1'b1;
						end
						if (cmd_q == CMD_RECV && bit_q == LAST_BIT) begin
							rx_nxt = line_q;
						end
						if (cmd_q == CMD_RACK) begin
							ack_nxt = ack_line_q;
						end
					end
				endcase
			end
			default: last_nxt = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_q <= 1'b1;
			sda_q <= 1'b1;
			ph_q  <= PH_DATA;
			bit_q <= '0;
		end else if (cmd.load) begin
			ph_q  <= PH_DATA;
			bit_q <= '0;
		end else if (cmd.step) begin
			scl_q <= scl_nxt;
			sda_q <= sda_nxt;
			ph_q  <= ph_nxt;
			if (shift_nxt) begin
				bit_q <= bit_q + 3'd1;
			end
		end
	end

	// latched command fields and result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q      <= in_data.command;
			sh_q       <= in_data.tx_byte;
			ack_out_q  <= in_data.ack_out;
			line_q     <= in_data.line_bits;
			ack_line_q <= in_data.ack_line;
		end else if (cmd.step && shift_nxt) begin
			sh_q <= {sh_q[BYTE_BITS-2:0], 1'b0};
		end
		if (cmd.step) begin
			out_q.scl_level <= scl_nxt;
			out_q.sda_level <= sda_nxt;
			out_q.rx_byte   <= rx_nxt;
			out_q.ack_in    <= ack_nxt;
			out_q.last      <= last_nxt;
		end
	end

	assign sts.cmd_ok    = (in_data.command <= CMD_RACK);
	assign sts.step_last = last_nxt;
	assign out_data      = out_q;

endmodule

// ----- hw/rtl/i2c_master_bit_sequencer_unit.sv -----
// I2C master bit sequencer, open-drain bit-bang style.
// Input channel (in_valid/in_ready/in_data): one bus command per transaction
// (start, stop, send byte, receive byte, send ack, receive ack), along with
// the byte to send, the ack level to drive and the SDA levels sampled on the
// line. Output channel (out_valid/out_ready/out_data): one transaction per
// line write, carrying SCL/SDA after that write; last marks the command's
// final write, which also carries rx_byte (receive byte) or ack_in
// (receive ack). Those fields read 0 on every other write.
// Writes per command: start 4, stop 3, send byte 24, receive byte 17,
// send/receive ack 3. The sequencer emits at most one write per cycle. A
// command is loaded in the idle state; its writes follow in the run state,
// each when the output register is empty or its write is being taken. Unused
// command codes are accepted and dropped with no write and no line change.
// One command runs at a time; the next is taken as soon as the final write
// sits in the output register, even if the receiver has not yet taken it.
// A stalled receiver holds the current write and pauses the sequencer.
// Reset: both lines released (SCL=1, SDA=1), no result pending, idle.
module i2c_master_bit_sequencer_unit
	import i2cms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  i2cms_in_t  in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output i2cms_out_t out_data
);

	i2cms_cmd_t cmd;
	i2cms_sts_t sts;

	// sequencing: idle/run plus output register occupancy
	i2cms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// line state, phase/bit counters, shift register, result register
	i2cms_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.out_data (out_data),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

// ----- tb/sv/i2c_master_bit_sequencer_unit_tb.sv -----
`timescale 1ns / 100ps

// Bus commands go in through in_valid/in_ready. Each line write comes back through
// out_valid/out_ready and is checked against a line-level model kept in this file.
module i2c_master_bit_sequencer_unit_tb;
	import i2cms_pkg::*;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	i2cms_in_t  in_data   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	i2cms_out_t out_data;

	i2c_master_bit_sequencer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Commands waiting for the driver, and line writes still owed by the DUT
	i2cms_in_t  pending_cmds[$];
	i2cms_out_t expected_writes[$];

	// Line levels as the model sees them; both released out of reset
	logic bus_scl = 1'b1;
	logic bus_sda = 1'b1;

	int   taken_cmds   = 0;  // commands accepted by the DUT
	int   planned_cmds = 0;  // commands queued that cause writes
	int   err_count    = 0;
	int   send_gap     = 0;
	int   recv_gap     = 0;
	logic calm         = 1'b0;  // no idling on either side
	logic long_hold    = 1'b0;  // receiver blocked for a long stretch
	i2cms_out_t want_write;

	// ------------------------------------------------------------------
	// Line model
	// ------------------------------------------------------------------

	// Record one write at the current line levels
	function automatic void note_write(logic [BYTE_BITS-1:0] rx, logic ack, logic fin);
		i2cms_out_t w;
		w.scl_level = bus_scl;
		w.sda_level = bus_sda;
		w.rx_byte   = rx;
		w.ack_in    = ack;
		w.last      = fin;
		expected_writes.push_back(w);
	endfunction

	// Work out the full write sequence of one accepted command.
	// Commands run from whatever levels the lines hold; no protocol checks.
	function automatic void predict_line_writes(i2cms_in_t c);
		logic fin;
		case (c.command)
			CMD_START: begin
				bus_sda = 1'b1; note_write('0, 1'b0, 1'b0);
				bus_scl = 1'b1; note_write('0, 1'b0, 1'b0);
				bus_sda = 1'b0; note_write('0, 1'b0, 1'b0);
				bus_scl = 1'b0; note_write('0, 1'b0, 1'b1);
			end
			CMD_STOP: begin
				bus_sda = 1'b0; note_write('0, 1'b0, 1'b0);
				bus_scl = 1'b1; note_write('0, 1'b0, 1'b0);
				bus_sda = 1'b1; note_write('0, 1'b0, 1'b1);
			end
			CMD_SEND: begin
				// MSB first, data set up while SCL is low
				for (int i = 0; i < BYTE_BITS; i++) begin
					fin = (i == BYTE_BITS - 1);
					bus_sda = c.tx_byte[BYTE_BITS-1-i]; note_write('0, 1'b0, 1'b0);
					bus_scl = 1'b1;                     note_write('0, 1'b0, 1'b0);
					bus_scl = 1'b0;                     note_write('0, 1'b0, fin);
				end
			end
			CMD_RECV: begin
				// SDA released once, then SCL pulsed for every bit; byte shows only on the final write
				bus_sda = 1'b1; note_write('0, 1'b0, 1'b0);
				for (int i = 0; i < BYTE_BITS; i++) begin
					fin = (i == BYTE_BITS - 1);
					bus_scl = 1'b1; note_write('0, 1'b0, 1'b0);
					bus_scl = 1'b0; note_write(fin ? c.line_bits : '0, 1'b0, fin);
				end
			end
			CMD_SACK: begin
				bus_sda = c.ack_out; note_write('0, 1'b0, 1'b0);
				bus_scl = 1'b1;      note_write('0, 1'b0, 1'b0);
				bus_scl = 1'b0;      note_write('0, 1'b0, 1'b1);
			end
			CMD_RACK: begin
				bus_sda = 1'b1; note_write('0, 1'b0, 1'b0);
				bus_scl = 1'b1; note_write('0, 1'b0, 1'b0);
				bus_scl = 1'b0; note_write('0, c.ack_line, 1'b1);
			end
			default: begin
				// unused codes: dropped, lines untouched
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Command driver: holds valid and payload until the transaction is taken
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				predict_line_writes(in_data);
				taken_cmds++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (!calm && pending_cmds.size() != 0 && $urandom_range(0, 7) == 0) begin
					// random idle burst, starting with this cycle
					send_gap = $urandom_range(0, 6);
					in_valid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					in_data  <= pending_cmds.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Write monitor and receiver backpressure
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_writes.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("%0t: unexpected write scl=%b sda=%b rx=%h ack=%b last=%b",
							$realtime, out_data.scl_level, out_data.sda_level,
							out_data.rx_byte, out_data.ack_in, out_data.last);
				end else begin
					want_write = expected_writes.pop_front();
					if (out_data.scl_level !== want_write.scl_level ||
					    out_data.sda_level !== want_write.sda_level ||
					    out_data.rx_byte   !== want_write.rx_byte   ||
					    out_data.ack_in    !== want_write.ack_in    ||
					    out_data.last      !== want_write.last) begin
						err_count++;
						if (err_count <= 10)
							$display("%0t: write mismatch exp scl=%b sda=%b rx=%h ack=%b last=%b, got scl=%b sda=%b rx=%h ack=%b last=%b",
								$realtime, want_write.scl_level, want_write.sda_level,
								want_write.rx_byte, want_write.ack_in, want_write.last,
								out_data.scl_level, out_data.sda_level,
								out_data.rx_byte, out_data.ack_in, out_data.last);
					end
				end
			end
			if (long_hold) begin
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 6);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Long receiver stall: output register fills, sequencer pauses, in_ready drops
	initial begin
		while (taken_cmds < 60)
			@(posedge clk);
		long_hold <= 1'b1;
		repeat (200) @(posedge clk);
		long_hold <= 1'b0;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	function automatic void add_cmd(logic [2:0] op, logic [7:0] tx, logic ack_o,
	                                logic [7:0] line, logic ack_l);
		i2cms_in_t c;
		c.command   = op;
		c.tx_byte   = tx;
		c.ack_out   = ack_o;
		c.line_bits = line;
		c.ack_line  = ack_l;
		pending_cmds.push_back(c);
		if (op <= CMD_RACK)
			planned_cmds++;
	endfunction

	// Fields the command does not use still get random values
	function automatic void add_rand(logic [2:0] op);
		add_cmd(op, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
	endfunction

	// One well-formed bus transfer: address, ack, data bytes, optional stop.
	// Skipping the stop turns the next start into a repeated start.
	function automatic void add_bus_transfer();
		logic [7:0] addr;
		int         nbytes;
		addr   = 8'($urandom);
		nbytes = $urandom_range(0, 3);
		add_rand(CMD_START);
		add_cmd(CMD_SEND, addr, 1'($urandom), 8'($urandom), 1'($urandom));
		add_rand(CMD_RACK);
		for (int i = 0; i < nbytes; i++) begin
			if (addr[0]) begin
				// master read: ack each byte, nack the final one
				add_rand(CMD_RECV);
				add_cmd(CMD_SACK, 8'($urandom), (i == nbytes - 1), 8'($urandom),
					1'($urandom));
			end else begin
				add_rand(CMD_SEND);
				add_rand(CMD_RACK);
			end
		end
		if ($urandom_range(0, 3) != 0)
			add_rand(CMD_STOP);
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: stop straight out of reset, repeated start, field extremes,
		// unused codes, and commands outside any protocol order
		add_rand(CMD_STOP);
		add_rand(CMD_START);
		add_rand(CMD_START);
		add_cmd(CMD_SEND, 8'h00, 1'b1, 8'hff, 1'b1);
		add_cmd(CMD_SEND, 8'hff, 1'b0, 8'h00, 1'b0);
		add_cmd(CMD_SEND, 8'ha5, 1'b0, 8'h00, 1'b0);
		add_cmd(CMD_RACK, 8'hff, 1'b1, 8'hff, 1'b0);
		add_cmd(CMD_RACK, 8'h00, 1'b0, 8'h00, 1'b1);
		add_cmd(CMD_RECV, 8'hff, 1'b1, 8'h00, 1'b1);
		add_cmd(CMD_RECV, 8'h00, 1'b0, 8'hff, 1'b0);
		add_cmd(CMD_RECV, 8'h3c, 1'b1, 8'h5a, 1'b1);
		add_cmd(CMD_SACK, 8'h00, 1'b0, 8'h00, 1'b1);
		add_cmd(CMD_SACK, 8'hff, 1'b1, 8'hff, 1'b0);
		add_cmd(3'd6, 8'h00, 1'b0, 8'h00, 1'b0);
		add_cmd(3'd7, 8'hff, 1'b1, 8'hff, 1'b1);
		add_cmd(CMD_SEND, 8'h80, 1'b1, 8'h01, 1'b0);
		add_rand(CMD_STOP);
		add_rand(CMD_STOP);
		add_cmd(CMD_RECV, 8'h7e, 1'b0, 8'h81, 1'b1);
		add_cmd(3'd6, 8'hff, 1'b1, 8'hff, 1'b1);
		add_rand(CMD_START);
		add_cmd(CMD_SEND, 8'h01, 1'b0, 8'h80, 1'b0);
		add_rand(CMD_STOP);

		// Sender pause: let every owed write come back before going on
		while (pending_cmds.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_writes.size() != 0)
			@(posedge clk);

		// Random: mostly whole transfers, some lone or unused commands as noise
		while (planned_cmds < 185) begin
			if ($urandom_range(0, 4) != 0)
				add_bus_transfer();
			else
				add_rand(3'($urandom_range(0, 7)));
		end

		// Final stretch with both sides running flat out
		while (pending_cmds.size() != 0)
			@(posedge clk);
		calm <= 1'b1;
		while (planned_cmds < 215)
			add_bus_transfer();

		while (pending_cmds.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_writes.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run
	initial begin
		#1000000;
		$display("status: fail");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/i2cms_pkg.sv
hw/rtl/i2cms_ctrl.sv
hw/rtl/i2cms_dp.sv
hw/rtl/i2c_master_bit_sequencer_unit.sv
tb/sv/i2c_master_bit_sequencer_unit_tb.sv
